>>> hdl/acs_pkg.sv
// types, codes and helpers shared by the acquisition link command sequencer
`timescale 1ns / 1ps

package acs_pkg;

   // channel count of the acquisition board (1 to 8, mask holds five)
   localparam int CHANNELS = 5;
   localparam logic [3:0] CHANNEL_COUNT = 4'(CHANNELS);
   localparam logic [4:0] ALL_MASK = 5'(((1 << CHANNELS) - 1) & 31);

   // word widths on the stream ports
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ID_PARITY = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_GAIN = 1'd1;

   // input word kinds
   localparam logic [2:0] KIND_FRAME  = 3'd0;
   localparam logic [2:0] KIND_LINK   = 3'd1;
   localparam logic [2:0] KIND_GAIN   = 3'd2;
   localparam logic [2:0] KIND_FILTER = 3'd3;
   localparam logic [2:0] KIND_INPUT  = 3'd4;

   // serial command codes
   localparam logic [1:0] CMD_NOP    = 2'd0;
   localparam logic [1:0] CMD_GAIN   = 2'd1;
   localparam logic [1:0] CMD_FILTER = 2'd2;
   localparam logic [1:0] CMD_INPUT  = 2'd3;

   // event codes
   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_LINK_UP   = 3'd1;
   localparam logic [2:0] EV_GAIN      = 3'd2;
   localparam logic [2:0] EV_FILTER    = 3'd3;
   localparam logic [2:0] EV_INPUT     = 3'd4;
   localparam logic [2:0] EV_LINK_DOWN = 3'd5;

   // link and initialisation machine
   typedef enum logic [3:0] {
      CP_LINK_DOWN  = 4'd0,
      CP_LINK_UP    = 4'd1,
      CP_GAINS      = 4'd2,
      CP_GAINS_WAIT = 4'd3,
      CP_HPFS       = 4'd4,
      CP_HPFS_WAIT  = 4'd5,
      CP_INSEL      = 4'd6,
      CP_INSEL_WAIT = 4'd7,
      CP_NORMAL     = 4'd8
   } ctrl_phase_type;

   // command machine
   typedef enum logic [3:0] {
      MP_NONE       = 4'd0,
      MP_GAIN_SET   = 4'd1,
      MP_GAIN_WAIT  = 4'd2,
      MP_GAIN_DONE  = 4'd3,
      MP_HPF_SET    = 4'd4,
      MP_HPF_WAIT   = 4'd5,
      MP_HPF_DONE   = 4'd6,
      MP_INSEL_SET  = 4'd7,
      MP_INSEL_WAIT = 4'd8,
      MP_INSEL_DONE = 4'd9
   } cmd_phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] frame_cmdid;
      logic [7:0] frame_mode;
      logic       link_up;
      logic [4:0] channel_mask;
      logic [7:0] gain_code;
      logic       filter_enable;
      logic [7:0] input_channel;
   } acs_item_type;

   typedef struct packed {
      logic        send_valid;
      logic [1:0]  cmd_code;
      logic [3:0]  cmd_id;
      logic [31:0] cmd_data;
      logic [2:0]  event_res;
      logic [4:0]  event_mask;
      logic [7:0]  event_value;
      logic        ready_res;
      logic        accepted;
   } acs_result_type;

   typedef struct packed {
      logic                   wr_en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } acs_csr_type;

   typedef struct packed {
      logic       found;
      logic [2:0] pos;
   } acs_first_type;

   // lowest channel present in a mask
   function automatic acs_first_type first_channel(input logic [4:0] mask);
      acs_first_type r;
      r = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (i < 5 && mask[i]) begin
            r.found = 1'b1;
            r.pos   = 3'(i);
         end
      end
      return r;
   endfunction

endpackage

>>> hdl/acs_core.sv
// sequencer state registers and the single-pass next-state and result logic
`timescale 1ns / 1ps

module acs_core
   import acs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  acs_item_type   item,
   input  acs_csr_type    csr,
   output acs_result_type result
);

   ctrl_phase_type ctrl_ff, ctrl_in;
   cmd_phase_type  cmd_ff, cmd_in;
   logic           link_ff, link_in;
   logic [3:0]     next_id_ff, next_id_in;
   logic [3:0]     pending_id_ff, pending_id_in;
   logic [4:0]     mask_ff, mask_in;
   logic [2:0]     pos_ff, pos_in;
   logic [7:0]     value_ff, value_in;
   logic [7:0]     init_gain_ff;

   // state registers, configuration write takes precedence
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff       <= CP_LINK_DOWN;
         cmd_ff        <= MP_NONE;
         link_ff       <= 1'b0;
         next_id_ff    <= 4'd0;
         pending_id_ff <= 4'd0;
         mask_ff       <= 5'd0;
         pos_ff        <= 3'd0;
         value_ff      <= 8'd0;
         init_gain_ff  <= 8'd0;
      end else begin
         ctrl_ff       <= ctrl_in;
         cmd_ff        <= cmd_in;
         link_ff       <= link_in;
         pending_id_ff <= pending_id_in;
         mask_ff       <= mask_in;
         pos_ff        <= pos_in;
         value_ff      <= value_in;
         next_id_ff    <= next_id_in;
         if (csr.wr_en && csr.index == CSR_ID_PARITY) begin
            next_id_ff   <= {3'd0, csr.wdata[0]};
         end
         if (csr.wr_en && csr.index == CSR_INIT_GAIN) begin
            init_gain_ff <= csr.wdata;
         end
      end
   end

   // control advance, masked start, command advance and send, in that order
   always_comb begin
      logic          idle;
      logic          start;
      logic [4:0]    start_mask;
      logic [7:0]    start_value;
      cmd_phase_type start_set;
      cmd_phase_type start_done;
      acs_first_type first;
      logic          do_send;
      logic [1:0]    send_code;
      logic [4:0]    shifted;
      logic [3:0]    pos_inc;

      ctrl_in       = ctrl_ff;
      cmd_in        = cmd_ff;
      link_in       = link_ff;
      next_id_in    = next_id_ff;
      pending_id_in = pending_id_ff;
      mask_in       = mask_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      result        = '0;
      idle          = (ctrl_ff == CP_NORMAL) && (cmd_ff == MP_NONE);
      start         = 1'b0;
      start_mask    = 5'd0;
      start_value   = 8'd0;
      start_set     = MP_GAIN_SET;
      start_done    = MP_GAIN_DONE;
      first         = '0;
      do_send       = 1'b0;
      send_code     = CMD_NOP;
      shifted       = 5'd0;
      pos_inc       = 4'd0;

      if (step) begin
         // first stage: item kind and link and initialisation machine
         case (item.kind)
            KIND_FRAME: begin
               case (ctrl_ff)
                  CP_LINK_DOWN: begin
                     if (link_ff) ctrl_in = CP_LINK_UP;
                  end
                  CP_LINK_UP: begin
                     if (next_id_in == item.frame_cmdid) next_id_in = next_id_in + 4'd2;
                     result.event_res   = EV_LINK_UP;
                     result.event_value = item.frame_mode;
                     ctrl_in = CP_GAINS;
                  end
                  CP_GAINS: begin
                     start       = 1'b1;
                     start_mask  = ALL_MASK;
                     start_value = init_gain_ff;
                     start_set   = MP_GAIN_SET;
                     start_done  = MP_GAIN_DONE;
                     ctrl_in     = CP_GAINS_WAIT;
                  end
                  CP_GAINS_WAIT: begin
                     if (cmd_ff == MP_GAIN_DONE) ctrl_in = CP_HPFS;
                  end
                  CP_HPFS: begin
                     start       = 1'b1;
                     start_mask  = ALL_MASK;
                     start_value = 8'd0;
                     start_set   = MP_HPF_SET;
                     start_done  = MP_HPF_DONE;
                     ctrl_in     = CP_HPFS_WAIT;
                  end
                  CP_HPFS_WAIT: begin
                     if (cmd_ff == MP_HPF_DONE) ctrl_in = CP_INSEL;
                  end
                  CP_INSEL: begin
                     value_in = 8'd0;
                     cmd_in   = MP_INSEL_SET;
                     ctrl_in  = CP_INSEL_WAIT;
                  end
                  CP_INSEL_WAIT: begin
                     if (cmd_ff == MP_INSEL_DONE) ctrl_in = CP_NORMAL;
                  end
                  default: begin
                  end
               endcase
            end
            KIND_LINK: begin
               if (link_ff != item.link_up) begin
                  link_in = item.link_up;
                  ctrl_in = CP_LINK_DOWN;
                  cmd_in  = MP_NONE;
                  if (!item.link_up) result.event_res = EV_LINK_DOWN;
               end
            end
            KIND_GAIN: begin
               if (idle) begin
                  start           = 1'b1;
                  start_mask      = item.channel_mask;
                  start_value     = item.gain_code;
                  start_set       = MP_GAIN_SET;
                  start_done      = MP_GAIN_DONE;
                  result.accepted = 1'b1;
               end
            end
            KIND_FILTER: begin
               if (idle) begin
                  start           = 1'b1;
                  start_mask      = item.channel_mask;
                  start_value     = {7'd0, item.filter_enable};
                  start_set       = MP_HPF_SET;
                  start_done      = MP_HPF_DONE;
                  result.accepted = 1'b1;
               end
            end
            KIND_INPUT: begin
               if (idle) begin
                  value_in        = item.input_channel;
                  cmd_in          = MP_INSEL_SET;
                  result.accepted = 1'b1;
               end
            end
            default: begin
            end
         endcase

         // masked run start: first channel in the mask or straight to done
         if (start) begin
            mask_in  = start_mask & ALL_MASK;
            value_in = start_value;
            first    = first_channel(mask_in);
            pos_in   = first.found ? first.pos : 3'd0;
            cmd_in   = first.found ? start_set : start_done;
         end

         // command machine, frames only
         if (item.kind == KIND_FRAME) begin
            shifted = mask_in >> pos_in;
            pos_inc = {1'b0, pos_in} + 4'd1;
            case (cmd_in)
               MP_GAIN_SET, MP_HPF_SET: begin
                  if (shifted[0]) begin
                     do_send   = 1'b1;
                     send_code = (cmd_in == MP_GAIN_SET) ? CMD_GAIN : CMD_FILTER;
                     cmd_in    = (cmd_in == MP_GAIN_SET) ? MP_GAIN_WAIT : MP_HPF_WAIT;
                  end else if (pos_inc >= CHANNEL_COUNT) begin
                     pos_in = 3'd0;
                     cmd_in = (cmd_in == MP_GAIN_SET) ? MP_GAIN_DONE : MP_HPF_DONE;
                  end else begin
                     pos_in = pos_inc[2:0];
                  end
               end
               MP_GAIN_WAIT, MP_HPF_WAIT: begin
                  if (item.frame_cmdid == pending_id_in) begin
                     if (pos_inc >= CHANNEL_COUNT) begin
                        pos_in = 3'd0;
                        cmd_in = (cmd_in == MP_GAIN_WAIT) ? MP_GAIN_DONE : MP_HPF_DONE;
                     end else begin
                        pos_in = pos_inc[2:0];
                        cmd_in = (cmd_in == MP_GAIN_WAIT) ? MP_GAIN_SET : MP_HPF_SET;
                     end
                  end
               end
               MP_GAIN_DONE, MP_HPF_DONE: begin
                  result.event_res   = (cmd_in == MP_GAIN_DONE) ? EV_GAIN : EV_FILTER;
                  result.event_mask  = mask_in;
                  result.event_value = value_in;
                  cmd_in = MP_NONE;
               end
               MP_INSEL_SET: begin
                  do_send   = 1'b1;
                  send_code = CMD_INPUT;
                  cmd_in    = MP_INSEL_WAIT;
               end
               MP_INSEL_WAIT: begin
                  if (item.frame_cmdid == pending_id_in) cmd_in = MP_INSEL_DONE;
               end
               MP_INSEL_DONE: begin
                  result.event_res   = EV_INPUT;
                  result.event_value = value_in;
                  cmd_in = MP_NONE;
               end
               default: begin
                  cmd_in = MP_NONE;
               end
            endcase
         end

         // serial command out, id steps by two
         if (do_send) begin
            next_id_in        = next_id_in + 4'd2;
            pending_id_in     = next_id_in;
            result.send_valid = 1'b1;
            result.cmd_code   = send_code;
            result.cmd_id     = next_id_in;
            if (send_code == CMD_INPUT) begin
               result.cmd_data = {value_in, 24'd0};
            end else begin
               result.cmd_data = {5'd0, pos_in, value_in, 16'd0};
            end
         end

         result.ready_res = (ctrl_in == CP_NORMAL);
      end
   end

endmodule

>>> hdl/acq_link_command_sequencer.sv
// top level: input word register, sequencer core and result register
`timescale 1ns / 1ps

// Acquisition link command sequencer.
// The req_ channel carries link changes, set requests and received frames,
// with the kind in req_tuser. The rsp_ channel returns exactly one word per
// request word: the serial command to send (if any), an event report, the
// normal-operation flag and whether a set request was taken.
// The csr_ port writes the starting id parity (which also reloads the next
// id) and the initialisation gain code; write only while the block is idle.
// A word accepted into the input register is processed from there and its
// result is offered on rsp_ from the result register.
// Throughput: one word per cycle while rsp_tready stays high; all next-state
// work is a single pass of logic between the input register and the result register.
// A stalled receiver holds the result register; the input register still
// takes one more word, then req_tready drops until the result moves on.
// Reset clears both registers, puts the link machine in link down, the
// command machine in no command and both configuration registers to zero.

module acq_link_command_sequencer
   import acs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // frame_cmdid, frame_mode, link_up, channel_mask, gain_code,
   // filter_enable, input_channel, zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic [2:0]             req_tuser,
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // cmd_code, cmd_id, cmd_data, event_mask, event_value, ready_res,
   // accepted, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // send_valid, event_res
   output logic [RSP_USER_W-1:0]  rsp_tuser,
   // configuration write port
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic           in_valid_ff;
   acs_item_type   in_item_ff, in_item_in;
   logic           out_valid_ff;
   acs_result_type out_ff;
   acs_result_type core_result;
   acs_csr_type    csr;
   logic           advance;

   // a word moves from input to result register when the result is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_item_in = '{
      kind:          req_tuser,
      frame_cmdid:   req_tdata[3:0],
      frame_mode:    req_tdata[11:4],
      link_up:       req_tdata[12],
      channel_mask:  req_tdata[17:13],
      gain_code:     req_tdata[25:18],
      filter_enable: req_tdata[26],
      input_channel: req_tdata[34:27]
   };

   assign csr = '{wr_en: csr_wr_en, index: csr_index, wdata: csr_wdata};

   // input word register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
   end

   acs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .csr    (csr),
      .result (core_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_ff.event_res, out_ff.send_valid};
   assign rsp_tdata  = {3'd0, out_ff.accepted, out_ff.ready_res, out_ff.event_value,
                        out_ff.event_mask, out_ff.cmd_data, out_ff.cmd_id, out_ff.cmd_code};

   // a sent command always carries a real command code
   a_send_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.send_valid |-> out_ff.cmd_code != CMD_NOP)
      else $error("command sent without a command code");

   // a taken set request neither sends nor reports in the same word
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.accepted |-> !out_ff.send_valid && out_ff.event_res == EV_NONE)
      else $error("accepted request also sent or reported");

   // input select puts only the channel in the top byte
   a_insel_data: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.send_valid && out_ff.cmd_code == CMD_INPUT
      |-> out_ff.cmd_data[23:0] == 24'd0)
      else $error("input select command with stray data bits");

   // a held input word is not lost or overwritten
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("pending input word overwritten");

endmodule

>>> dv/tb_acq_link_command_sequencer.sv
// testbench for the acquisition link command sequencer: tracking model and random streams
`timescale 1ns / 1ps

import acs_pkg::*;

// follows both state machines and queues the result word due for each request word
class sequencer_tracker;
   ctrl_phase_type ctrl_ph;
   cmd_phase_type  cmd_ph;
   logic           link_on;
   logic           id_parity;
   logic [7:0]     init_gain;
   logic [3:0]     next_id;
   logic [3:0]     pend_id;
   logic [4:0]     act_mask;
   logic [2:0]     chan_pos;
   logic [7:0]     cmd_value;
   acs_result_type res;
   acs_result_type due_responses[$];
   int             errors;

   function new();
      ctrl_ph   = CP_LINK_DOWN;
      cmd_ph    = MP_NONE;
      link_on   = 1'b0;
      id_parity = 1'b0;
      init_gain = 8'd0;
      next_id   = 4'd0;
      pend_id   = 4'd0;
      act_mask  = 5'd0;
      chan_pos  = 3'd0;
      cmd_value = 8'd0;
      errors    = 0;
   endfunction

   function bit is_idle();
      return ctrl_ph == CP_NORMAL && cmd_ph == MP_NONE;
   endfunction

   // parity write also reloads the next id
   function void write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      if (idx == CSR_ID_PARITY) begin
         id_parity = value[0];
         next_id   = {3'd0, value[0]};
      end else begin
         init_gain = value;
      end
   endfunction

   // point at the lowest masked channel, or straight to done for an empty mask
   function void start_masked(input logic [4:0] mask, input logic [7:0] value,
                              input cmd_phase_type set_ph, input cmd_phase_type done_ph);
      act_mask  = mask & ALL_MASK;
      cmd_value = value;
      chan_pos  = 3'd0;
      cmd_ph    = done_ph;
      for (int i = 0; i < CHANNELS; i++) begin
         if (act_mask[i]) begin
            chan_pos = 3'(i);
            cmd_ph   = set_ph;
            break;
         end
      end
   endfunction

   function void send_command(input logic [1:0] code);
      next_id          = next_id + 4'd2;
      pend_id          = next_id;
      res.send_valid   = 1'b1;
      res.cmd_code     = code;
      res.cmd_id       = next_id;
      if (code == CMD_INPUT) begin
         res.cmd_data = {cmd_value, 24'd0};
      end else begin
         res.cmd_data = {5'd0, chan_pos, cmd_value, 16'd0};
      end
   endfunction

   function void step_channel(input cmd_phase_type next_ph, input cmd_phase_type done_ph);
      chan_pos = chan_pos + 3'd1;
      if (chan_pos >= CHANNELS) begin
         chan_pos = 3'd0;
         cmd_ph   = done_ph;
      end else begin
         cmd_ph = next_ph;
      end
   endfunction

   function void masked_set(input logic [1:0] code, input cmd_phase_type set_ph,
                            input cmd_phase_type wait_ph, input cmd_phase_type done_ph);
      if (act_mask[chan_pos]) begin
         send_command(code);
         cmd_ph = wait_ph;
      end else begin
         step_channel(set_ph, done_ph);
      end
   endfunction

   // link and initialisation machine, one frame at a time
   function void control_step(input logic [3:0] cmdid, input logic [7:0] mode);
      case (ctrl_ph)
         CP_LINK_DOWN: if (link_on) ctrl_ph = CP_LINK_UP;
         CP_LINK_UP: begin
            if (next_id == cmdid) next_id = next_id + 4'd2;
            res.event_res   = EV_LINK_UP;
            res.event_value = mode;
            ctrl_ph         = CP_GAINS;
         end
         CP_GAINS: begin
            start_masked(ALL_MASK, init_gain, MP_GAIN_SET, MP_GAIN_DONE);
            ctrl_ph = CP_GAINS_WAIT;
         end
         CP_GAINS_WAIT: if (cmd_ph == MP_GAIN_DONE) ctrl_ph = CP_HPFS;
         CP_HPFS: begin
            start_masked(ALL_MASK, 8'd0, MP_HPF_SET, MP_HPF_DONE);
            ctrl_ph = CP_HPFS_WAIT;
         end
         CP_HPFS_WAIT: if (cmd_ph == MP_HPF_DONE) ctrl_ph = CP_INSEL;
         CP_INSEL: begin
            cmd_value = 8'd0;
            cmd_ph    = MP_INSEL_SET;
            ctrl_ph   = CP_INSEL_WAIT;
         end
         CP_INSEL_WAIT: if (cmd_ph == MP_INSEL_DONE) ctrl_ph = CP_NORMAL;
         default: ;
      endcase
   endfunction

   // command machine, after the control machine on the same frame
   function void command_step(input logic [3:0] cmdid);
      case (cmd_ph)
         MP_GAIN_SET:  masked_set(CMD_GAIN, MP_GAIN_SET, MP_GAIN_WAIT, MP_GAIN_DONE);
         MP_GAIN_WAIT: if (cmdid == pend_id) step_channel(MP_GAIN_SET, MP_GAIN_DONE);
         MP_GAIN_DONE: begin
            res.event_res   = EV_GAIN;
            res.event_mask  = act_mask;
            res.event_value = cmd_value;
            cmd_ph          = MP_NONE;
         end
         MP_HPF_SET:   masked_set(CMD_FILTER, MP_HPF_SET, MP_HPF_WAIT, MP_HPF_DONE);
         MP_HPF_WAIT:  if (cmdid == pend_id) step_channel(MP_HPF_SET, MP_HPF_DONE);
         MP_HPF_DONE: begin
            res.event_res   = EV_FILTER;
            res.event_mask  = act_mask;
            res.event_value = cmd_value;
            cmd_ph          = MP_NONE;
         end
         MP_INSEL_SET: begin
            send_command(CMD_INPUT);
            cmd_ph = MP_INSEL_WAIT;
         end
         MP_INSEL_WAIT: if (cmdid == pend_id) cmd_ph = MP_INSEL_DONE;
         MP_INSEL_DONE: begin
            res.event_res   = EV_INPUT;
            res.event_value = cmd_value;
            cmd_ph          = MP_NONE;
         end
         default: cmd_ph = MP_NONE;
      endcase
   endfunction

   // accepted request word: advance the model and queue its result word
   function void note_word(input acs_item_type w);
      bit idle;
      idle = is_idle();
      res  = '0;
      case (w.kind)
         KIND_FRAME: begin
            control_step(w.frame_cmdid, w.frame_mode);
            command_step(w.frame_cmdid);
         end
         KIND_LINK: begin
            if (link_on != w.link_up) begin
               link_on = w.link_up;
               ctrl_ph = CP_LINK_DOWN;
               cmd_ph  = MP_NONE;
               if (!w.link_up) res.event_res = EV_LINK_DOWN;
            end
         end
         KIND_GAIN: begin
            if (idle) begin
               start_masked(w.channel_mask, w.gain_code, MP_GAIN_SET, MP_GAIN_DONE);
               res.accepted = 1'b1;
            end
         end
         KIND_FILTER: begin
            if (idle) begin
               start_masked(w.channel_mask, {7'd0, w.filter_enable}, MP_HPF_SET, MP_HPF_DONE);
               res.accepted = 1'b1;
            end
         end
         KIND_INPUT: begin
            if (idle) begin
               cmd_value    = w.input_channel;
               cmd_ph       = MP_INSEL_SET;
               res.accepted = 1'b1;
            end
         end
         default: ;
      endcase
      res.ready_res = (ctrl_ph == CP_NORMAL);
      due_responses.push_back(res);
   endfunction

   // compare a received result word with the oldest one due
   function void check_word(input acs_result_type got);
      acs_result_type want;
      if (due_responses.size() == 0) begin
         errors++;
         if (errors <= 10) $display("result word with nothing due: %h", got);
         return;
      end
      want = due_responses.pop_front();
      if (got !== want) begin
         errors++;
         if (errors <= 10) begin
            $display("mismatch (expected/actual): send %0d/%0d code %0d/%0d id %0d/%0d",
                     want.send_valid, got.send_valid, want.cmd_code, got.cmd_code,
                     want.cmd_id, got.cmd_id);
            $display("  data %h/%h event %0d/%0d mask %h/%h value %h/%h",
                     want.cmd_data, got.cmd_data, want.event_res, got.event_res,
                     want.event_mask, got.event_mask, want.event_value, got.event_value);
            $display("  ready %0d/%0d accepted %0d/%0d",
                     want.ready_res, got.ready_res, want.accepted, got.accepted);
         end
      end
   endfunction
endclass

module tb_acq_link_command_sequencer;

   localparam int CYCLE_LIMIT = 200000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [2:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   sequencer_tracker tracker;
   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   logic hold_rx = 1'b0;
   int  cycles = 0;

   acq_link_command_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: check the word taken at this edge, then choose the next ready
   always @(posedge clock) begin : rx_side
      acs_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.send_valid  = rsp_tuser[0];
         got.event_res   = rsp_tuser[3:1];
         got.cmd_code    = rsp_tdata[1:0];
         got.cmd_id      = rsp_tdata[5:2];
         got.cmd_data    = rsp_tdata[37:6];
         got.event_mask  = rsp_tdata[42:38];
         got.event_value = rsp_tdata[50:43];
         got.ready_res   = rsp_tdata[51];
         got.accepted    = rsp_tdata[52];
         tracker.check_word(got);
      end
      rsp_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic acs_item_type random_word();
      acs_item_type w;
      w.kind          = 3'($urandom_range(7));
      w.frame_cmdid   = 4'($urandom_range(15));
      w.frame_mode    = 8'($urandom_range(255));
      w.link_up       = 1'($urandom_range(1));
      w.channel_mask  = 5'($urandom_range(31));
      w.gain_code     = 8'($urandom_range(255));
      w.filter_enable = 1'($urandom_range(1));
      w.input_channel = 8'($urandom_range(255));
      return w;
   endfunction

   // frame that echoes the id still outstanding
   function automatic acs_item_type echo_frame();
      acs_item_type w;
      w             = random_word();
      w.kind        = KIND_FRAME;
      w.frame_cmdid = tracker.pend_id;
      return w;
   endfunction

   // mostly well-formed traffic steered by the tracked state, some noise
   function automatic acs_item_type pick_word();
      acs_item_type w;
      int r;
      w = random_word();
      r = $urandom_range(999);
      if (!tracker.link_on) begin
         if (r < 850) begin
            w.kind    = KIND_LINK;
            w.link_up = 1'b1;
         end else if (r < 900) begin
            w.kind = 3'($urandom_range(7, 5));
         end else begin
            w.kind = 3'($urandom_range(4, 0));
         end
      end else if (r < 15) begin
         w.kind = KIND_LINK;
      end else if (r < 40) begin
         w.kind = 3'($urandom_range(7, 5));
      end else if (r < 60 || (tracker.is_idle() && r < 600)) begin
         w.kind = 3'($urandom_range(4, 2));
      end else begin
         w.kind = KIND_FRAME;
         if (r % 5 != 0) begin
            if (tracker.ctrl_ph == CP_LINK_UP && r % 2 == 0) w.frame_cmdid = tracker.next_id;
            else w.frame_cmdid = tracker.pend_id;
         end
      end
      // lean on the empty and the full mask
      if (w.kind == KIND_GAIN || w.kind == KIND_FILTER) begin
         r = $urandom_range(9);
         if (r == 0) w.channel_mask = 5'd0;
         else if (r == 1) w.channel_mask = 5'h1F;
      end
      return w;
   endfunction

   // offer one word, idling first at random, and note it once taken
   task automatic send_word(input acs_item_type w);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.kind;
      req_tdata  <= {5'd0, w.input_channel, w.filter_enable, w.gain_code, w.channel_mask,
                     w.link_up, w.frame_mode, w.frame_cmdid};
      do @(posedge clock); while (!req_tready);
      tracker.note_word(w);
   endtask

   task automatic run_to_idle();
      while (!tracker.is_idle()) send_word(echo_frame());
   endtask

   // wait until every result word is back and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.due_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic parity, input logic [7:0] gain);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ID_PARITY;
      csr_wdata <= {7'd0, parity};
      @(posedge clock);
      tracker.write_reg(CSR_ID_PARITY, {7'd0, parity});
      csr_index <= CSR_INIT_GAIN;
      csr_wdata <= gain;
      @(posedge clock);
      tracker.write_reg(CSR_INIT_GAIN, gain);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_directed();
      acs_item_type w;
      // unknown kinds with every field at its top value
      for (int k = 5; k <= 7; k++) begin
         w      = '1;
         w.kind = 3'(k);
         send_word(w);
      end
      // set request refused while the link is down
      w      = '1;
      w.kind = KIND_GAIN;
      send_word(w);
      // frame with the link down, then an unchanged link level
      w      = '0;
      w.kind = KIND_FRAME;
      send_word(w);
      w.kind = KIND_LINK;
      send_word(w);
      // link up reports nothing until the mode frame
      w.link_up = 1'b1;
      send_word(w);
      w      = '0;
      w.kind = KIND_FRAME;
      send_word(w);
      // mode frame echoes the next id, which has to step past it
      w.frame_cmdid = tracker.next_id;
      w.frame_mode  = 8'hFF;
      send_word(w);
      run_to_idle();
      // empty mask goes straight to done
      w      = '0;
      w.kind = KIND_GAIN;
      send_word(w);
      run_to_idle();
      // filter on for every channel, input request refused while busy
      w      = '1;
      w.kind = KIND_FILTER;
      send_word(w);
      w.kind = KIND_INPUT;
      send_word(w);
      run_to_idle();
      // top input channel, then a sparse gain mask
      send_word(w);
      run_to_idle();
      w              = '0;
      w.kind         = KIND_GAIN;
      w.channel_mask = 5'b10100;
      send_word(w);
      run_to_idle();
      // link drop
      w      = '0;
      w.kind = KIND_LINK;
      send_word(w);
   endtask

   task automatic run_random(input int count, input int hold_at);
      acs_item_type w;
      int  taken;
      bit  ignored;
      taken = 0;
      while (taken < count) begin
         // long receiver hold while words keep coming
         if (taken == hold_at) begin
            hold_at = -1;
            fork
               begin
                  hold_rx <= 1'b1;
                  repeat (80) @(posedge clock);
                  hold_rx <= 1'b0;
               end
            join_none
         end
         w       = pick_word();
         ignored = (w.kind > KIND_INPUT) || (w.kind == KIND_LINK && w.link_up == tracker.link_on);
         send_word(w);
         if (!ignored) taken++;
      end
   endtask

   initial begin
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 28;
      rx_idle_pct = 64;
      configure(1'b1, 8'hFF);
      run_directed();
      settle();
      configure(1'b0, 8'h00);
      run_random(340, 100);
      settle();

      tx_idle_pct = 64;
      rx_idle_pct = 28;
      configure(1'b1, 8'($urandom_range(254, 1)));
      run_random(340, -1);
      settle();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      configure(1'b0, 8'hFF);
      run_random(340, 150);
      settle();

      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.due_responses.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/acs_pkg.sv
hdl/acs_core.sv
hdl/acq_link_command_sequencer.sv
dv/tb_acq_link_command_sequencer.sv
